// ----- rtl/core/dclr_pkg.sv -----
// Package with protocol bytes, parser state codes and the result word type.
`timescale 1ns / 1ps

package dclr_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h7E;
    localparam logic [BYTE_W-1:0] MY_ADDR    = 8'h80;
    localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h7F;
    localparam logic [BYTE_W-1:0] ESC_OFFSET = 8'h4E;

    localparam logic [BYTE_W-1:0] CHANNEL_COUNT_RESET = 8'd8;

    localparam int unsigned ST_W = 3;
    localparam logic [ST_W-1:0] ST_WAIT  = 3'd0;
    localparam logic [ST_W-1:0] ST_ADDR  = 3'd1;
    localparam logic [ST_W-1:0] ST_STRIP = 3'd2;
    localparam logic [ST_W-1:0] ST_ESC   = 3'd3;
    localparam logic [ST_W-1:0] ST_FWD   = 3'd4;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              chan_write;
        logic [BYTE_W-1:0] chan_index;
        logic [BYTE_W-1:0] chan_value;
        logic              frame_done;
    } t_result;

endpackage

// ----- rtl/core/daisy_chain_lighting_rx.sv -----
// Daisy-chain lighting receiver: frame parser with a two-entry result buffer.
//
// Usage:
//   rx channel  (i_rx_valid / o_rx_ready, i_rx_byte): one serial byte per word.
//   result channel (o_res_valid / i_res_ready): one result word per rx word,
//     carrying the downstream byte (o_tx_valid, o_tx_byte), the channel write
//     (o_chan_write, o_chan_index, o_chan_value) and o_frame_done.
//   config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): channel count,
//     always ready; write only while the block is idle.
// Buffering: each result word is registered in the output entry, or in the skid entry while the output is stalled.
// Throughput: one rx word per cycle while the skid entry is empty; the parser state update is a single
//   compare-and-increment step on the state and channel position registers.
// Reset: the parser waits for sync, channel position is zero, channel count
//   returns to 8, and both result buffer entries are empty.
// Stall: when the receiver holds i_res_ready low, one more rx word is taken
//   into the skid entry; o_rx_ready then drops until the stall clears.
`timescale 1ns / 1ps

module daisy_chain_lighting_rx (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_chan_write,
    output logic [7:0] o_chan_index,
    output logic [7:0] o_chan_value,
    output logic       o_frame_done
);

    logic [dclr_pkg::ST_W-1:0]   r_state, n_state;
    logic [dclr_pkg::BYTE_W-1:0] r_pos, n_pos;
    logic [dclr_pkg::BYTE_W-1:0] r_count;
    dclr_pkg::t_result           n_res;
    dclr_pkg::t_result           r_out, r_skid;
    logic                        r_out_valid, r_skid_valid;
    logic                        in_fire, out_fire;
    logic [dclr_pkg::BYTE_W-1:0] chan_val;
    logic [dclr_pkg::BYTE_W-1:0] pos_inc;
    logic                        do_chan;

    assign o_rx_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_rx_valid && o_rx_ready;
    assign out_fire    = r_out_valid && i_res_ready;
    assign pos_inc     = r_pos + 8'd1;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_res    = '0;
        do_chan  = 1'b0;
        chan_val = i_rx_byte;
        unique case (r_state)
            dclr_pkg::ST_ADDR: begin
                if (i_rx_byte == dclr_pkg::MY_ADDR) begin
                    n_state = dclr_pkg::ST_STRIP;
                    n_pos   = '0;
                end else if (i_rx_byte > dclr_pkg::MY_ADDR) begin
                    n_state        = dclr_pkg::ST_FWD;
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = i_rx_byte - 8'd1;
                end
            end
            dclr_pkg::ST_STRIP: begin
                if (i_rx_byte == dclr_pkg::ESC_BYTE) begin
                    n_state = dclr_pkg::ST_ESC;
                end else if (i_rx_byte != dclr_pkg::PAD_BYTE) begin
                    do_chan = 1'b1;
                end
            end
            dclr_pkg::ST_ESC: begin
                do_chan  = 1'b1;
                chan_val = i_rx_byte + dclr_pkg::ESC_OFFSET;
            end
            dclr_pkg::ST_FWD: begin
                if (i_rx_byte == dclr_pkg::SYNC_BYTE) begin
                    n_state = dclr_pkg::ST_ADDR;
                end
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = i_rx_byte;
            end
            default: begin
                if (i_rx_byte == dclr_pkg::SYNC_BYTE) begin
                    n_state        = dclr_pkg::ST_ADDR;
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = dclr_pkg::SYNC_BYTE;
                end else begin
                    n_state = dclr_pkg::ST_WAIT;
                end
            end
        endcase
        if (do_chan) begin
            n_res.chan_write = 1'b1;
            n_res.chan_index = r_pos;
            n_res.chan_value = chan_val;
            n_pos            = pos_inc;
            if (pos_inc == r_count) begin
                n_state          = dclr_pkg::ST_FWD;
                n_res.tx_valid   = 1'b1;
                n_res.tx_byte    = dclr_pkg::MY_ADDR;
                n_res.frame_done = 1'b1;
            end else begin
                n_state = dclr_pkg::ST_STRIP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dclr_pkg::ST_WAIT;
            r_pos   <= '0;
            r_count <= dclr_pkg::CHANNEL_COUNT_RESET;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
                r_pos   <= n_pos;
            end
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_res;
            end
        end else if (in_fire) begin
            r_skid <= n_res;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_tx_valid   = r_out.tx_valid;
    assign o_tx_byte    = r_out.tx_byte;
    assign o_chan_write = r_out.chan_write;
    assign o_chan_index = r_out.chan_index;
    assign o_chan_value = r_out.chan_value;
    assign o_frame_done = r_out.frame_done;

endmodule

// ----- rtl/core/dclr_checker.sv -----
// Port-level checker for the daisy-chain lighting receiver, bound to the top level.
`timescale 1ns / 1ps

module dclr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_rx_ready,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_chan_write,
    input logic [7:0] o_chan_index,
    input logic [7:0] o_chan_value,
    input logic       o_frame_done
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_tx_valid)
            && $stable(o_tx_byte) && $stable(o_chan_write)
            && $stable(o_chan_index) && $stable(o_chan_value)
            && $stable(o_frame_done))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res_valid |-> o_rx_ready)
        else $error("rx not ready while result buffer empty");

    a_done_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_done |-> o_tx_valid && o_chan_write
            && o_tx_byte == dclr_pkg::MY_ADDR)
        else $error("frame end without address byte and channel write");

    a_idle_chan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_chan_write |-> o_chan_index == 8'd0
            && o_chan_value == 8'd0 && !o_frame_done)
        else $error("channel fields set without channel write");

    a_idle_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_tx_valid |-> o_tx_byte == 8'd0)
        else $error("tx byte set without tx valid");

endmodule

bind daisy_chain_lighting_rx dclr_checker u_dclr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_rx_ready   (o_rx_ready),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_tx_valid   (o_tx_valid),
    .o_tx_byte    (o_tx_byte),
    .o_chan_write (o_chan_write),
    .o_chan_index (o_chan_index),
    .o_chan_value (o_chan_value),
    .o_frame_done (o_frame_done)
);

// ----- sim/daisy_chain_lighting_rx_test.sv -----
// Self-checking testbench for the daisy-chain lighting receiver: directed and random byte streams.
`timescale 1ns / 1ps

module daisy_chain_lighting_rx_test;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int RANDOM_BYTES  = 460;

    typedef enum logic [1:0] {
        STIM_BYTE,
        STIM_CFG,
        STIM_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind kind;
        logic [7:0] value;
    } t_stim_item;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_cfg_ready;
    logic       o_res_valid;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_chan_write;
    logic [7:0] o_chan_index;
    logic [7:0] o_chan_value;
    logic       o_frame_done;

    daisy_chain_lighting_rx uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_chan_write (o_chan_write),
        .o_chan_index (o_chan_index),
        .o_chan_value (o_chan_value),
        .o_frame_done (o_frame_done)
    );

    t_stim_item          pending_words[$];
    dclr_pkg::t_result   expected_results[$];

    logic [dclr_pkg::ST_W-1:0] model_state;
    logic [7:0]                rx_pos;
    logic [7:0]                node_channels;

    logic quiet_mode = 1'b0;
    int   send_gap;
    int   idle_run;
    int   stall_left;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   queued_bytes = 0;
    int   bytes_taken = 0;
    int   chan_writes = 0;
    int   frames_done = 0;
    int   cfg_writes = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic push_byte(input logic [7:0] b);
        pending_words.push_back('{kind: STIM_BYTE, value: b});
        queued_bytes++;
    endtask

    task automatic push_cfg(input logic [7:0] v);
        pending_words.push_back('{kind: STIM_DRAIN, value: 8'h00});
        pending_words.push_back('{kind: STIM_CFG, value: v});
    endtask

    task automatic push_drain();
        pending_words.push_back('{kind: STIM_DRAIN, value: 8'h00});
    endtask

    function automatic logic [7:0] plain_channel_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == dclr_pkg::PAD_BYTE || b == dclr_pkg::ESC_BYTE);
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void take_channel(input logic [7:0] v, inout dclr_pkg::t_result r);
        r.chan_write = 1'b1;
        r.chan_index = rx_pos;
        r.chan_value = v;
        rx_pos = rx_pos + 8'd1;
        if (rx_pos == node_channels) begin
            model_state = dclr_pkg::ST_FWD;
            r.tx_valid = 1'b1;
            r.tx_byte = dclr_pkg::MY_ADDR;
            r.frame_done = 1'b1;
        end else begin
            model_state = dclr_pkg::ST_STRIP;
        end
    endfunction

    function automatic dclr_pkg::t_result parse_byte(input logic [7:0] b);
        dclr_pkg::t_result r;
        r = '0;
        case (model_state)
            dclr_pkg::ST_ADDR: begin
                if (b == dclr_pkg::MY_ADDR) begin
                    model_state = dclr_pkg::ST_STRIP;
                    rx_pos = 8'd0;
                end else if (b > dclr_pkg::MY_ADDR) begin
                    model_state = dclr_pkg::ST_FWD;
                    r.tx_valid = 1'b1;
                    r.tx_byte = b - 8'd1;
                end
            end
            dclr_pkg::ST_STRIP: begin
                if (b == dclr_pkg::ESC_BYTE) begin
                    model_state = dclr_pkg::ST_ESC;
                end else if (b != dclr_pkg::PAD_BYTE) begin
                    take_channel(b, r);
                end
            end
            dclr_pkg::ST_ESC: begin
                take_channel(b + dclr_pkg::ESC_OFFSET, r);
            end
            dclr_pkg::ST_FWD: begin
                if (b == dclr_pkg::SYNC_BYTE) model_state = dclr_pkg::ST_ADDR;
                r.tx_valid = 1'b1;
                r.tx_byte = b;
            end
            default: begin
                if (b == dclr_pkg::SYNC_BYTE) begin
                    model_state = dclr_pkg::ST_ADDR;
                    r.tx_valid = 1'b1;
                    r.tx_byte = dclr_pkg::SYNC_BYTE;
                end else begin
                    model_state = dclr_pkg::ST_WAIT;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : drive_words
        logic       nxt_rx_valid;
        logic [7:0] nxt_rx_byte;
        logic       nxt_cfg_valid;
        logic [7:0] nxt_cfg_data;
        nxt_rx_valid  = i_rx_valid;
        nxt_rx_byte   = i_rx_byte;
        nxt_cfg_valid = i_cfg_valid;
        nxt_cfg_data  = i_cfg_data;
        if (!i_rst_n) begin
            nxt_rx_valid  = 1'b0;
            nxt_cfg_valid = 1'b0;
            send_gap = 0;
            idle_run = 0;
        end else if (!(i_rx_valid && !o_rx_ready) && !(i_cfg_valid && !o_cfg_ready)) begin
            nxt_rx_valid  = 1'b0;
            nxt_cfg_valid = 1'b0;
            if (i_rx_valid) send_gap = pick_gap();
            if (i_rx_valid || i_cfg_valid || expected_results.size() != 0) begin
                idle_run = 0;
            end else if (idle_run < SETTLE_CYCLES) begin
                idle_run++;
            end
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_words.size() != 0) begin
                case (pending_words[0].kind)
                    STIM_BYTE: begin
                        nxt_rx_valid = 1'b1;
                        nxt_rx_byte = pending_words[0].value;
                        void'(pending_words.pop_front());
                    end
                    STIM_CFG: begin
                        if (idle_run >= SETTLE_CYCLES) begin
                            nxt_cfg_valid = 1'b1;
                            nxt_cfg_data = pending_words[0].value;
                            void'(pending_words.pop_front());
                        end
                    end
                    default: begin
                        if (idle_run >= SETTLE_CYCLES) void'(pending_words.pop_front());
                    end
                endcase
            end
        end
        i_rx_valid  <= nxt_rx_valid;
        i_rx_byte   <= nxt_rx_byte;
        i_cfg_valid <= nxt_cfg_valid;
        i_cfg_data  <= nxt_cfg_data;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if ($urandom_range(0, 299) == 0) quiet_mode <= ~quiet_mode;
            if (stall_left > 0) begin
                stall_left--;
                i_res_ready <= 1'b0;
            end else begin
                stall_left = ($urandom_range(0, 5) == 0) ? pick_gap() : 0;
                i_res_ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        dclr_pkg::t_result got;
        dclr_pkg::t_result want;
        if (!i_rst_n) begin
            model_state = dclr_pkg::ST_WAIT;
            rx_pos = 8'd0;
            node_channels = dclr_pkg::CHANNEL_COUNT_RESET;
        end else begin
            if (o_res_valid && i_res_ready) begin
                got = {o_tx_valid, o_tx_byte, o_chan_write, o_chan_index, o_chan_value,
                       o_frame_done};
                if (got.chan_write === 1'b1) chan_writes++;
                if (got.frame_done === 1'b1) frames_done++;
                if (expected_results.size() == 0) begin
                    $error("result word with no byte outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.tx_valid !== want.tx_valid) begin
                        $error("tx_valid: expected %0h, actual %0h", want.tx_valid, got.tx_valid);
                        mismatches++;
                    end
                    if (got.tx_byte !== want.tx_byte) begin
                        $error("tx_byte: expected %0h, actual %0h", want.tx_byte, got.tx_byte);
                        mismatches++;
                    end
                    if (got.chan_write !== want.chan_write) begin
                        $error("chan_write: expected %0h, actual %0h",
                               want.chan_write, got.chan_write);
                        mismatches++;
                    end
                    if (got.chan_index !== want.chan_index) begin
                        $error("chan_index: expected %0h, actual %0h",
                               want.chan_index, got.chan_index);
                        mismatches++;
                    end
                    if (got.chan_value !== want.chan_value) begin
                        $error("chan_value: expected %0h, actual %0h",
                               want.chan_value, got.chan_value);
                        mismatches++;
                    end
                    if (got.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0h, actual %0h",
                               want.frame_done, got.frame_done);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                node_channels = i_cfg_data;
                cfg_writes++;
            end
            if (i_rx_valid && o_rx_ready) begin
                expected_results.push_back(parse_byte(i_rx_byte));
                bytes_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int         phase;
        int         count;
        int         frames;
        int         n;
        int         r;
        int         big_left;
        int         directed_bytes;
        logic [7:0] directed[$];

        // wait-state noise, sync echo, sync and low address ignored, then an 8-channel frame
        directed = {8'h00, 8'hFF, dclr_pkg::SYNC_BYTE, dclr_pkg::SYNC_BYTE, 8'h10,
                    dclr_pkg::MY_ADDR, dclr_pkg::PAD_BYTE, dclr_pkg::ESC_BYTE, 8'hFF,
                    dclr_pkg::ESC_BYTE, dclr_pkg::ESC_BYTE, dclr_pkg::SYNC_BYTE, 8'h00, 8'hFF,
                    dclr_pkg::ESC_BYTE, 8'hB2, dclr_pkg::PAD_BYTE, 8'h01, 8'h55,
                    8'hAA, dclr_pkg::SYNC_BYTE, 8'hFF, 8'h00, dclr_pkg::SYNC_BYTE, 8'h81};
        foreach (directed[k]) push_byte(directed[k]);
        directed_bytes = queued_bytes;

        // lower the count below the position mid-frame, then strip until it wraps
        push_cfg(8'd10);
        push_byte(dclr_pkg::SYNC_BYTE);
        push_byte(dclr_pkg::MY_ADDR);
        repeat (6) push_byte(plain_channel_byte());
        push_cfg(8'd3);
        repeat (253) push_byte(plain_channel_byte());
        push_byte(8'h42);
        directed_bytes = queued_bytes;

        phase = 0;
        big_left = 0;
        while (queued_bytes - directed_bytes < RANDOM_BYTES) begin
            if (phase == 0) begin
                count = 1;
            end else if (phase == 1) begin
                count = 255;
            end else begin
                r = $urandom_range(0, 19);
                if (r == 0 && big_left > 0) begin
                    count = 255;
                    big_left--;
                end else if (r < 4) begin
                    count = 1;
                end else begin
                    count = $urandom_range(2, 12);
                end
            end
            push_cfg(8'(count));
            frames = (count > 40) ? 1 : $urandom_range(2, 6);
            repeat (frames) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
                end
                push_byte(dclr_pkg::SYNC_BYTE);
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(0, 8'h7F)));
                end
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    push_byte(dclr_pkg::MY_ADDR);
                    n = count;
                    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, count - 1);
                    repeat (n) begin
                        r = $urandom_range(0, 19);
                        if (r < 3) begin
                            repeat ($urandom_range(1, 2)) push_byte(dclr_pkg::PAD_BYTE);
                            push_byte(plain_channel_byte());
                        end else if (r < 6) begin
                            push_byte(dclr_pkg::ESC_BYTE);
                            push_byte(8'($urandom_range(0, 255)));
                        end else begin
                            push_byte(plain_channel_byte());
                        end
                    end
                end else if (r < 9) begin
                    push_byte(8'($urandom_range(8'h81, 8'hFF)));
                end else begin
                    push_byte(8'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0) push_drain();
            end
            phase++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_words.size() != 0 || i_rx_valid || i_cfg_valid ||
               expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d result words never arrived", expected_results.size());
            mismatches++;
        end

        $display("Covered %0d bytes over %0d count settings: %0d channel writes, %0d frames done.",
                 bytes_taken, cfg_writes, chan_writes, frames_done);
        $display("Streams mixed sync hunt, forwarding, pads, escapes and broken frames.");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
